>>> rtl/owm_pkg.sv
// Shared types, codes and register defaults of the 1-Wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

  localparam int CFG_W      = 10;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 5;
  localparam int NUM_REGS   = 7;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [2:0] REG_RESET_LOW   = 3'd0;
  localparam logic [2:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [2:0] REG_PRES_TAIL   = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW    = 3'd3;
  localparam logic [2:0] REG_ONE_LOW     = 3'd4;
  localparam logic [2:0] REG_READ_LOW    = 3'd5;
  localparam logic [2:0] REG_SLOT        = 3'd6;

  localparam logic [CFG_W-1:0] RESET_LOW_DEF   = 10'd480;
  localparam logic [CFG_W-1:0] PRES_SAMPLE_DEF = 10'd60;
  localparam logic [CFG_W-1:0] PRES_TAIL_DEF   = 10'd420;
  localparam logic [CFG_W-1:0] ZERO_LOW_DEF    = 10'd60;
  localparam logic [CFG_W-1:0] ONE_LOW_DEF     = 10'd5;
  localparam logic [CFG_W-1:0] READ_LOW_DEF    = 10'd1;
  localparam logic [CFG_W-1:0] SLOT_DEF        = 10'd61;

  localparam logic [1:0] FUNC_RESET = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_sample_ticks;
    logic [CFG_W-1:0] presence_tail_ticks;
    logic [CFG_W-1:0] zero_low_ticks;
    logic [CFG_W-1:0] one_low_ticks;
    logic [CFG_W-1:0] read_low_ticks;
    logic [CFG_W-1:0] slot_ticks;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       start_req;
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       bus_level;
  } req_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
  } res_t;

endpackage

>>> rtl/onewire_bus_master_unit.sv
// Top level of the 1-Wire bus master: request stream in, line state stream out.
//
//   channel  ports        direction  carries
//   in_      in_t*        slave      one request per clock or tick sample
//   out_     out_t*       master     line control and status after each request
//   cfg_     cfg_p*       APB        seven 10-bit timing registers at 4*i
//
// One request per cycle; the state update and result are one combinational pass
// into the result register. Synchronous active-low reset clears the sequencer
// and loads the default timings. A stalled result holds in the result register
// and in_tready drops until it is taken.
`timescale 1ns / 1ps

module onewire_bus_master_unit #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tick, start_req, write_byte[7:0], bus_level, zero pad
  input  logic [owm_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [owm_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // drive_enable, drive_level, busy_res, done_res, presence, read_byte[7:0], zero pad
  output logic [owm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [owm_pkg::APB_AW-1:0]     cfg_paddr,
  input  logic [owm_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [owm_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  owm_pkg::cfg_t cfg;
  owm_pkg::req_t req;
  owm_pkg::res_t res;
  owm_pkg::res_t res_r;
  logic          out_valid_r;
  logic          accept;

  assign req.tick       = in_tdata[0];
  assign req.start_req  = in_tdata[1];
  assign req.write_byte = in_tdata[9:2];
  assign req.bus_level  = in_tdata[10];
  assign req.func       = in_tuser;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  owm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  owm_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .req   (req),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_tready);
    end
    if (accept) res_r <= res;
  end

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.read_byte, res_r.presence, res_r.done_res,
                       res_r.busy_res, res_r.drive_level, res_r.drive_enable};

endmodule

>>> rtl/owm_regs.sv
// Configuration register file with APB-style write and read access.
`timescale 1ns / 1ps

module owm_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [owm_pkg::APB_AW-1:0] paddr,
  input  logic [owm_pkg::APB_DW-1:0] pwdata,
  output logic [owm_pkg::APB_DW-1:0] prdata,
  output owm_pkg::cfg_t              cfg
);

  owm_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  logic wr_en;
  logic [owm_pkg::CFG_W-1:0] wval;
  logic [owm_pkg::CFG_W-1:0] rval;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign wval  = pwdata[owm_pkg::CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks       <= owm_pkg::RESET_LOW_DEF;
      cfg_r.presence_sample_ticks <= owm_pkg::PRES_SAMPLE_DEF;
      cfg_r.presence_tail_ticks   <= owm_pkg::PRES_TAIL_DEF;
      cfg_r.zero_low_ticks        <= owm_pkg::ZERO_LOW_DEF;
      cfg_r.one_low_ticks         <= owm_pkg::ONE_LOW_DEF;
      cfg_r.read_low_ticks        <= owm_pkg::READ_LOW_DEF;
      cfg_r.slot_ticks            <= owm_pkg::SLOT_DEF;
    end else if (wr_en) begin
      case (idx)
        owm_pkg::REG_RESET_LOW:   cfg_r.reset_low_ticks       <= wval;
        owm_pkg::REG_PRES_SAMPLE: cfg_r.presence_sample_ticks <= wval;
        owm_pkg::REG_PRES_TAIL:   cfg_r.presence_tail_ticks   <= wval;
        owm_pkg::REG_ZERO_LOW:    cfg_r.zero_low_ticks        <= wval;
        owm_pkg::REG_ONE_LOW:     cfg_r.one_low_ticks         <= wval;
        owm_pkg::REG_READ_LOW:    cfg_r.read_low_ticks        <= wval;
        owm_pkg::REG_SLOT:        cfg_r.slot_ticks            <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      owm_pkg::REG_RESET_LOW:   rval = cfg_r.reset_low_ticks;
      owm_pkg::REG_PRES_SAMPLE: rval = cfg_r.presence_sample_ticks;
      owm_pkg::REG_PRES_TAIL:   rval = cfg_r.presence_tail_ticks;
      owm_pkg::REG_ZERO_LOW:    rval = cfg_r.zero_low_ticks;
      owm_pkg::REG_ONE_LOW:     rval = cfg_r.one_low_ticks;
      owm_pkg::REG_READ_LOW:    rval = cfg_r.read_low_ticks;
      owm_pkg::REG_SLOT:        rval = cfg_r.slot_ticks;
      default:                  rval = '0;
    endcase
  end

  assign prdata = owm_pkg::APB_DW'(rval);
  assign cfg    = cfg_r;

endmodule

>>> rtl/owm_core.sv
// Bus sequencer: command state, slot timer, bit shifter and line control.
`timescale 1ns / 1ps

module owm_core #(
  parameter int TIMER_WIDTH = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  owm_pkg::req_t req,
  input  owm_pkg::cfg_t cfg,
  output owm_pkg::res_t res
);

  localparam int EW = (TIMER_WIDTH > owm_pkg::CFG_W) ? TIMER_WIDTH : owm_pkg::CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TMASK = '1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT_LOW, PH_SLOT_HIGH
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [TIMER_WIDTH-1:0] tc_r, tc_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   pres_r, pres_nxt;
  logic                   en_r, en_nxt;
  logic                   lvl_r, lvl_nxt;
  logic [7:0]             rd_r, rd_nxt;
  logic                   done;

  function automatic logic [EW-1:0] eff(input logic [owm_pkg::CFG_W-1:0] v);
    logic [EW-1:0] ext;
    ext = EW'(v);
    return (ext > EW'(TMASK)) ? EW'(TMASK) : ext;
  endfunction

  always_comb begin
    logic [EW-1:0] tcx;
    logic [EW-1:0] slot;
    logic [EW-1:0] low;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    tc_nxt    = tc_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    en_nxt    = en_r;
    lvl_nxt   = lvl_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    slot      = eff(cfg.slot_ticks);
    tcx       = '0;
    low       = '0;
    if (phase_r == PH_IDLE) begin
      if (req.start_req && (req.func == owm_pkg::FUNC_RESET ||
          req.func == owm_pkg::FUNC_WRITE || req.func == owm_pkg::FUNC_READ)) begin
        op_nxt  = req.func;
        tc_nxt  = '0;
        bit_nxt = '0;
        en_nxt  = 1'b1;
        lvl_nxt = 1'b0;
        if (req.func == owm_pkg::FUNC_RESET) begin
          phase_nxt = PH_RST_LOW;
        end else begin
          shift_nxt = (req.func == owm_pkg::FUNC_WRITE) ? req.write_byte : 8'h00;
          phase_nxt = PH_SLOT_LOW;
        end
      end
    end else if (req.tick) begin
      if (tc_r != TMASK) tc_nxt = tc_r + 1'b1;
      tcx = EW'(tc_nxt);
      case (phase_r)
        PH_RST_LOW: begin
          if (tcx >= eff(cfg.reset_low_ticks)) begin
            en_nxt    = 1'b0;
            tc_nxt    = '0;
            phase_nxt = PH_RST_WAIT;
          end
        end
        PH_RST_WAIT: begin
          if (tcx >= eff(cfg.presence_sample_ticks)) begin
            pres_nxt = !req.bus_level;
            tc_nxt   = '0;
            if (eff(cfg.presence_tail_ticks) == '0) done = 1'b1;
            else phase_nxt = PH_RST_TAIL;
          end
        end
        PH_RST_TAIL: begin
          if (tcx >= eff(cfg.presence_tail_ticks)) done = 1'b1;
        end
        PH_SLOT_LOW, PH_SLOT_HIGH: begin
          if (phase_r == PH_SLOT_LOW) begin
            if (op_r == owm_pkg::FUNC_WRITE) begin
              low = shift_r[0] ? eff(cfg.one_low_ticks) : eff(cfg.zero_low_ticks);
              if (tcx >= low || tcx >= slot) begin
                en_nxt    = 1'b1;
                lvl_nxt   = 1'b1;
                phase_nxt = PH_SLOT_HIGH;
              end
            end else begin
              if (tcx >= eff(cfg.read_low_ticks) || tcx >= slot) begin
                en_nxt    = 1'b0;
                shift_nxt = {req.bus_level, shift_r[7:1]};
                phase_nxt = PH_SLOT_HIGH;
              end
            end
          end
          if (phase_nxt == PH_SLOT_HIGH && tcx >= slot) begin
            if (op_r == owm_pkg::FUNC_WRITE) shift_nxt = {1'b0, shift_nxt[7:1]};
            if (bit_r == 3'd7) begin
              if (op_r == owm_pkg::FUNC_READ) rd_nxt = shift_nxt;
              done = 1'b1;
            end else begin
              bit_nxt   = bit_r + 1'b1;
              tc_nxt    = '0;
              en_nxt    = 1'b1;
              lvl_nxt   = 1'b0;
              phase_nxt = PH_SLOT_LOW;
            end
          end
        end
        default: ;
      endcase
      if (done) begin
        phase_nxt = PH_IDLE;
        tc_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= '0;
      tc_r    <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      en_r    <= 1'b1;
      lvl_r   <= 1'b1;
      rd_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      tc_r    <= tc_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      en_r    <= en_nxt;
      lvl_r   <= lvl_nxt;
      rd_r    <= rd_nxt;
    end
  end

  assign res.drive_enable = en_nxt;
  assign res.drive_level  = lvl_nxt;
  assign res.busy_res     = (phase_nxt != PH_IDLE);
  assign res.done_res     = done;
  assign res.presence     = pres_nxt;
  assign res.read_byte    = rd_nxt;

endmodule
